// ===== hw/rtl/led_strip_pattern_engine_core_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef LED_STRIP_PATTERN_ENGINE_CORE_MACROS_SVH
`define LED_STRIP_PATTERN_ENGINE_CORE_MACROS_SVH

// Concurrent assertion sampled on a clock, off while reset is active.
`define LSPE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication from a condition to a consequence in the same cycle.
`define LSPE_ASSERT_IMP(lbl, clk, rst_n, cond, cons, msg) \
  `LSPE_ASSERT(lbl, clk, rst_n, (cond) |-> (cons), msg)

// Implication from a condition to a consequence in the next cycle.
`define LSPE_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  `LSPE_ASSERT(lbl, clk, rst_n, (cond) |=> (cons), msg)

`endif

// ===== hw/rtl/lspe_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine package
// Operation codes, input modes, pattern codes, configuration indexes, the command item type and wipe colours.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lspe_pkg;

  // Input modes.
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_WRITE   = 3'd1;
  localparam logic [2:0] MODE_FILL    = 3'd2;
  localparam logic [2:0] MODE_START   = 3'd3;
  localparam logic [2:0] MODE_REFRESH = 3'd4;

  // Pattern codes.
  localparam logic [3:0] PAT_OFF     = 4'd0;
  localparam logic [3:0] PAT_RED     = 4'd1;
  localparam logic [3:0] PAT_RAINBOW = 4'd2;
  localparam logic [3:0] PAT_CHASE   = 4'd3;
  localparam logic [3:0] PAT_FADE    = 4'd4;
  localparam logic [3:0] PAT_TWINKLE = 4'd5;
  localparam logic [3:0] PAT_FIRE    = 4'd6;
  localparam logic [3:0] PAT_RAIN    = 4'd7;
  localparam logic [3:0] PAT_WIPE    = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PATTERN  = 2'd0;
  localparam logic [1:0] CFG_BRIGHT   = 2'd1;
  localparam logic [1:0] CFG_INTERVAL = 2'd2;

  // Operations handed from the front to the back.
  localparam logic [3:0] OP_ERROR   = 4'd0;
  localparam logic [3:0] OP_WRITE   = 4'd1;
  localparam logic [3:0] OP_FILL    = 4'd2;
  localparam logic [3:0] OP_START   = 4'd3;
  localparam logic [3:0] OP_REFRESH = 4'd4;
  localparam logic [3:0] OP_CHASE   = 4'd5;
  localparam logic [3:0] OP_FADE    = 4'd6;
  localparam logic [3:0] OP_TWINKLE = 4'd7;
  localparam logic [3:0] OP_WIPE    = 4'd8;

  localparam int unsigned WipeColours = 6;

  // One classified command.
  typedef struct packed {
    logic [3:0]  op;
    logic [7:0]  idx;
    logic [23:0] colour;
  } cmd_t;

  // Colour of the wipe for a given selector.
  function automatic logic [23:0] wipe_colour(input logic [2:0] sel);
    logic [23:0] c;
    case (sel)
      3'd0: c = 24'hFF0000;
      3'd1: c = 24'h00FF00;
      3'd2: c = 24'h0000FF;
      3'd3: c = 24'hFFFF00;
      3'd4: c = 24'h00FFFF;
      3'd5: c = 24'hFF00FF;
      default: c = 24'hFF0000;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/led_strip_pattern_engine_core.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine core
// Keeps a pixel frame, runs the animations and sends each frame as a run.
// ----------------------------------------------------------------------------
// Input items arrive on a queue-like port: an item is taken when push is
// high and full is low. Results leave the same way: the oldest result sits
// on the output ports while empty is low and is taken when pop is high.
// A front stage classifies each item and throttles ticks against the frame
// interval; a two-entry command queue feeds the back stage, which sweeps
// the frame memory one pixel at a time.
// Each pixel takes a memory read, then an update and send, through the
// single-port frame memory. A bad pixel write gives a single error result.
// When the receiver stalls, the output register holds and the back stage
// waits; the command queue keeps taking items until it is full.
// Reset clears the frame to black (per-pixel valid bits), the animation
// counters and the configuration to pattern off, brightness 50, interval 50.
// Configuration is written by cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write it only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_strip_pattern_engine_core
  import lspe_pkg::*;
#(
  parameter int unsigned PixelCount = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  out_index_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_brightness_o,
  output logic        bad_index_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [3:0]  pattern_q;
  logic [7:0]  bright_q;
  logic [15:0] interval_q;
  logic        accept, f_push, c_empty, c_pop;
  cmd_t        f_cmd, c_cmd;
  logic [23:0] out_colour;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= PAT_OFF;
      bright_q   <= 8'd50;
      interval_q <= 16'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN:  pattern_q  <= cfg_data_i[3:0];
        CFG_BRIGHT:   bright_q   <= cfg_data_i[7:0];
        CFG_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  lspe_front #(.PixelCount(PixelCount)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (mode_i),
    .now_ms_i      (now_ms_i),
    .pixel_index_i (pixel_index_i),
    .colour_i      ({red_in_i, green_in_i, blue_in_i}),
    .pattern_i     (pattern_q),
    .interval_i    (interval_q),
    .push_o        (f_push),
    .cmd_o         (f_cmd)
  );

  lspe_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .cmd_i   (f_cmd),
    .full_o  (full),
    .pop_i   (c_pop),
    .cmd_o   (c_cmd),
    .empty_o (c_empty)
  );

  lspe_back #(.PixelCount(PixelCount)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (c_empty),
    .cmd_i        (c_cmd),
    .cmd_pop_o    (c_pop),
    .pattern_i    (pattern_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_index_o  (out_index_o),
    .out_colour_o (out_colour),
    .bad_index_o  (bad_index_o),
    .last_o       (last_o)
  );

  assign out_red_o        = out_colour[23:16];
  assign out_green_o      = out_colour[15:8];
  assign out_blue_o       = out_colour[7:0];
  assign out_brightness_o = bright_q;

endmodule

// ===== hw/rtl/lspe_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine command queue
// Two-entry queue of commands between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lspe_cmd_fifo
  import lspe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/lspe_front.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine front
// Classifies input items into commands and throttles animation ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lspe_front
  import lspe_pkg::*;
#(
  parameter int unsigned PixelCount = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [2:0]  mode_i,
  input  logic [31:0] now_ms_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [23:0] colour_i,
  input  logic [3:0]  pattern_i,
  input  logic [15:0] interval_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [31:0] last_step_q, last_step_d;
  logic [31:0] delta;
  logic        due;

  assign delta = now_ms_i - last_step_q;
  assign due   = (delta >= {16'd0, interval_i});

  // Classification of one item.
  always_comb begin
    push_o         = 1'b0;
    cmd_o.op       = OP_REFRESH;
    cmd_o.idx      = pixel_index_i;
    cmd_o.colour   = colour_i;
    last_step_d    = last_step_q;
    case (mode_i)
      MODE_TICK: begin
        if (pattern_i >= PAT_CHASE && due) begin
          last_step_d = now_ms_i;
          push_o      = 1'b1;
          case (pattern_i)
            PAT_CHASE:   cmd_o.op = OP_CHASE;
            PAT_FADE:    cmd_o.op = OP_FADE;
            PAT_TWINKLE: cmd_o.op = OP_TWINKLE;
            PAT_WIPE:    cmd_o.op = OP_WIPE;
            default:     push_o   = 1'b0;
          endcase
        end
      end
      MODE_WRITE: begin
        push_o   = 1'b1;
        cmd_o.op = (pixel_index_i >= 8'(PixelCount)) ? OP_ERROR : OP_WRITE;
      end
      MODE_FILL: begin
        push_o   = 1'b1;
        cmd_o.op = OP_FILL;
      end
      MODE_START: begin
        push_o   = 1'b1;
        cmd_o.op = OP_START;
      end
      MODE_REFRESH: begin
        push_o   = 1'b1;
        cmd_o.op = OP_REFRESH;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    if (!accept_i) begin
      push_o      = 1'b0;
      last_step_d = last_step_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_step_q <= 32'd0;
    end else begin
      last_step_q <= last_step_d;
    end
  end

endmodule

// ===== hw/rtl/lspe_back.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine back
// Sweeps the frame per command and sends one result per pixel, or one error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lspe_back
  import lspe_pkg::*;
#(
  parameter int unsigned PixelCount = 60
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_empty_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [3:0]  pattern_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [5:0]  out_index_o,
  output logic [23:0] out_colour_o,
  output logic        bad_index_o,
  output logic        last_o
);

  localparam int unsigned IdxW = $clog2(PixelCount);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(PixelCount - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_ERR  = 2'd3;

  logic [1:0]      st_q, st_d;
  cmd_t            cmd_q;
  logic [IdxW-1:0] cnt_q;
  logic [7:0]      rb_r_q, rb_b_q;
  logic [IdxW-1:0] h1_q, h2_q;
  logic [IdxW-1:0] chase_head_q, wipe_head_q;
  logic [7:0]      fade_level_q;
  logic            fade_fall_q;
  logic [2:0]      wipe_sel_q;
  logic [23:0]     mem [PixelCount];
  logic [PixelCount-1:0] vld_q;
  logic [23:0]     rd_data_q;
  logic            rd_vld_q;
  logic            out_valid_q;
  logic [5:0]      out_idx_q;
  logic [23:0]     out_rgb_q;
  logic            out_bad_q, out_last_q;

  logic            out_free, emit, pass_end;
  logic [23:0]     old_c, new_c;
  logic [8:0]      rb_r_sum, rb_b_sum;
  logic [7:0]      rb_g;
  logic [IdxW-1:0] head_inc, h1_inc;
  logic signed [9:0] fade_v;

  // Brightness scaling by 95/100 via reciprocal multiply.
  function automatic logic [7:0] scale95(input logic [7:0] c);
    logic [26:0] q;
    q = 27'(c) * 27'd498085;
    return q[26:19];
  endfunction

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] v);
    return (v == LastIdx) ? '0 : v + IdxW'(1);
  endfunction

  assign out_free  = !out_valid_q || pop_i;
  assign emit      = (st_q == ST_EMIT) && out_free;
  assign pass_end  = emit && (cnt_q == LastIdx);
  assign cmd_pop_o = (st_q == ST_IDLE) && !cmd_empty_i;
  assign old_c     = rd_vld_q ? rd_data_q : 24'd0;
  assign head_inc  = wrap_inc(chase_head_q);
  assign h1_inc    = wrap_inc(head_inc);

  // Running rainbow components.
  assign rb_r_sum = {1'b0, rb_r_q} + 9'd40;
  assign rb_b_sum = {1'b0, rb_b_q} + 9'd80;
  always_comb begin
    if (rb_r_q == 8'd0) begin
      rb_g = 8'd0;
    end else if (int'(cnt_q) <= 6) begin
      rb_g = 8'd255 - rb_r_q;
    end else begin
      rb_g = 8'd0 - rb_r_q;
    end
  end

  // New colour of the pixel under the sweep.
  always_comb begin
    new_c = old_c;
    case (cmd_q.op)
      OP_WRITE: begin
        new_c = ({{(8-IdxW){1'b0}}, cnt_q} == cmd_q.idx) ? cmd_q.colour : old_c;
      end
      OP_FILL:    new_c = cmd_q.colour;
      OP_START: begin
        case (pattern_i)
          PAT_OFF, PAT_CHASE, PAT_FADE, PAT_TWINKLE, PAT_RAIN, PAT_WIPE: new_c = 24'd0;
          PAT_RED:     new_c = 24'hFF0000;
          PAT_RAINBOW: new_c = {rb_r_q, rb_g, rb_b_q};
          PAT_FIRE:    new_c = 24'h0A0000;
          default:     new_c = old_c;
        endcase
      end
      OP_CHASE: begin
        if (cnt_q == chase_head_q) begin
          new_c = 24'h0000FF;
        end else if (cnt_q == h1_q) begin
          new_c = 24'h0000C3;
        end else if (cnt_q == h2_q) begin
          new_c = 24'h000087;
        end else begin
          new_c = 24'd0;
        end
      end
      OP_FADE:    new_c = {fade_level_q, 8'd0, fade_level_q};
      OP_TWINKLE: new_c = {scale95(old_c[23:16]), scale95(old_c[15:8]), scale95(old_c[7:0])};
      OP_WIPE:    new_c = (cnt_q == wipe_head_q) ? wipe_colour(wipe_sel_q) : old_c;
      default:    new_c = old_c;
    endcase
  end

  assign fade_v = fade_fall_q ? $signed({2'b00, fade_level_q}) - 10'sd5
                              : $signed({2'b00, fade_level_q}) + 10'sd5;

  // Sequencer state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          st_d = (cmd_i.op == OP_ERROR) ? ST_ERR : ST_READ;
        end
      end
      ST_READ: st_d = ST_EMIT;
      ST_EMIT: begin
        if (emit) begin
          st_d = pass_end ? ST_IDLE : ST_READ;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control registers and animation counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      cnt_q        <= '0;
      chase_head_q <= '0;
      fade_level_q <= 8'd0;
      fade_fall_q  <= 1'b0;
      wipe_head_q  <= '0;
      wipe_sel_q   <= 3'd0;
      vld_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cmd_pop_o) begin
        cnt_q <= '0;
      end else if (emit) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      // A wipe that wraps clears the whole frame; otherwise mark the sent pixel.
      if (pass_end && (cmd_q.op == OP_WIPE) && (wipe_head_q == LastIdx)) begin
        vld_q <= '0;
      end else if (emit) begin
        vld_q[cnt_q] <= 1'b1;
      end
      if (pass_end) begin
        case (cmd_q.op)
          OP_CHASE: chase_head_q <= head_inc;
          OP_FADE: begin
            if (fade_v >= 10'sd255) begin
              fade_level_q <= 8'd255;
              fade_fall_q  <= 1'b1;
            end else if (fade_v <= 10'sd0) begin
              fade_level_q <= 8'd0;
              fade_fall_q  <= 1'b0;
            end else begin
              fade_level_q <= fade_v[7:0];
            end
          end
          OP_WIPE: begin
            if (wipe_head_q == LastIdx) begin
              wipe_head_q <= '0;
              wipe_sel_q  <= (wipe_sel_q == 3'(WipeColours - 1)) ? 3'd0 : wipe_sel_q + 3'd1;
            end else begin
              wipe_head_q <= wipe_head_q + IdxW'(1);
            end
          end
          default: ;
        endcase
      end
      if (emit || ((st_q == ST_ERR) && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, frame memory and its registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q  <= cmd_i;
      rb_r_q <= 8'd0;
      rb_b_q <= 8'd0;
      h1_q   <= head_inc;
      h2_q   <= h1_inc;
    end
    if (st_q == ST_READ) begin
      rd_data_q <= mem[cnt_q];
      rd_vld_q  <= vld_q[cnt_q];
    end
    if (emit) begin
      mem[cnt_q] <= new_c;
      rb_r_q     <= (rb_r_sum >= 9'd255) ? 8'(rb_r_sum - 9'd255) : rb_r_sum[7:0];
      rb_b_q     <= (rb_b_sum >= 9'd255) ? 8'(rb_b_sum - 9'd255) : rb_b_sum[7:0];
      out_idx_q  <= 6'(cnt_q);
      out_rgb_q  <= new_c;
      out_bad_q  <= 1'b0;
      out_last_q <= (cnt_q == LastIdx);
    end else if ((st_q == ST_ERR) && out_free) begin
      out_idx_q  <= 6'd0;
      out_rgb_q  <= 24'd0;
      out_bad_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_index_o  = out_idx_q;
  assign out_colour_o = out_rgb_q;
  assign bad_index_o  = out_bad_q;
  assign last_o       = out_last_q;

endmodule

// ===== hw/rtl/lspe_checker.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "led_strip_pattern_engine_core_macros.svh"

module lspe_checker #(
  parameter int unsigned PixelCount = 60
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [5:0] out_index_o,
  input logic [7:0] out_red_o,
  input logic [7:0] out_green_o,
  input logic [7:0] out_blue_o,
  input logic       bad_index_o,
  input logic       last_o
);

  // A waiting result holds while the receiver stalls.
  `LSPE_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_index_o) && $stable(last_o), "result changed while stalled")

  // An error result is a single all-zero result that closes its run.
  `LSPE_ASSERT_IMP(a_err, clk_i, rst_ni, !empty && bad_index_o, last_o && out_index_o == 6'd0 && out_red_o == 8'd0 && out_green_o == 8'd0 && out_blue_o == 8'd0, "malformed error result")

  // A frame run closes on its final pixel.
  `LSPE_ASSERT_IMP(a_last, clk_i, rst_ni, !empty && last_o && !bad_index_o, out_index_o == 6'(PixelCount - 1), "frame closed early")

  // Inside a frame the next result is the next pixel.
  `LSPE_ASSERT_NEXT(a_seq, clk_i, rst_ni, !empty && pop && !last_o, empty || (!bad_index_o && out_index_o == $past(out_index_o) + 6'd1), "pixel order broken")

endmodule

bind led_strip_pattern_engine_core lspe_checker #(.PixelCount(PixelCount)) u_lspe_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// LED strip pattern engine testbench
// Drives pixel writes, fills, pattern starts, refreshes and ticks through the
// queue ports under several register settings and compares every pixel run
// against an in-bench model of the frame and animation counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import lspe_pkg::*;

  localparam int unsigned PixCount   = 60;
  localparam int unsigned DrainWait  = 2 * PixCount + 20;
  localparam int unsigned CycleLimit = 6000000;
  localparam logic [1:0]  CFG_SPARE  = 2'd3;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_MODEL,
    ROW_SOLID,
    ROW_BAD
  } row_kind_e;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] now;
    logic [7:0]  idx;
    logic [23:0] rgb;
    row_kind_e   kind;
  } stim_row_t;

  typedef struct {
    logic [5:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] bright;
    logic       bad;
    logic       last;
  } pixel_res_t;

  // Register settings of one phase.
  typedef struct {
    logic [15:0] pat;
    logic [15:0] bright;
    logic [15:0] interval;
    int          items;
    int          tick_pct;
    bit          idle_free;
  } phase_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [2:0]  mode_i;
  logic [31:0] now_ms_i;
  logic [7:0]  pixel_index_i;
  logic [7:0]  red_in_i;
  logic [7:0]  green_in_i;
  logic [7:0]  blue_in_i;
  logic        empty;
  logic        pop;
  logic [5:0]  out_index_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic [7:0]  out_brightness_o;
  logic        bad_index_o;
  logic        last_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  led_strip_pattern_engine_core u_top (.*);

  // Model state of the engine.
  logic [3:0]  m_pattern;
  logic [7:0]  m_bright;
  logic [15:0] m_interval;
  logic [23:0] m_frame [PixCount];
  logic [31:0] m_last_step;
  int          m_chase_head;
  int          m_fade_level;
  bit          m_fade_falling;
  int          m_wipe_head;
  int          m_wipe_sel;

  pixel_res_t  pending_pixels [$];
  int          mismatches;
  int unsigned cycles;
  bit          idle_free;
  bit          hold_req;

  // Clock and cycle watchdog.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (idle_free || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void queue_frame();
    pixel_res_t p;
    for (int i = 0; i < PixCount; i++) begin
      p.idx    = i[5:0];
      p.red    = m_frame[i][23:16];
      p.green  = m_frame[i][15:8];
      p.blue   = m_frame[i][7:0];
      p.bright = m_bright;
      p.bad    = 1'b0;
      p.last   = (i == PixCount - 1);
      pending_pixels.push_back(p);
    end
  endfunction

  function automatic void fill_model(input logic [23:0] c);
    for (int i = 0; i < PixCount; i++) m_frame[i] = c;
  endfunction

  function automatic logic [23:0] wipe_rgb(input int sel);
    case (sel)
      0: return 24'hFF0000;
      1: return 24'h00FF00;
      2: return 24'h0000FF;
      3: return 24'hFFFF00;
      4: return 24'h00FFFF;
      default: return 24'hFF00FF;
    endcase
  endfunction

  // Animation step on a tick that passed the interval check.
  function automatic void step_animation();
    int v;
    int unsigned lane;
    int unsigned m;
    case (m_pattern)
      PAT_CHASE: begin
        fill_model(24'h0);
        for (int k = 0; k < 3; k++) begin
          lane = 255 - k * 60;
          m_frame[(m_chase_head + k) % PixCount] = {16'h0, lane[7:0]};
        end
        m_chase_head = (m_chase_head + 1) % PixCount;
        queue_frame();
      end
      PAT_FADE: begin
        fill_model({m_fade_level[7:0], 8'h0, m_fade_level[7:0]});
        v = m_fade_level + (m_fade_falling ? -5 : 5);
        if (v >= 255) begin
          v = 255;
          m_fade_falling = 1'b1;
        end else if (v <= 0) begin
          v = 0;
          m_fade_falling = 1'b0;
        end
        m_fade_level = v;
        queue_frame();
      end
      PAT_TWINKLE: begin
        for (int i = 0; i < PixCount; i++) begin
          for (int b = 0; b < 3; b++) begin
            m = m_frame[i][b*8 +: 8];
            m = m * 95 / 100;
            m_frame[i][b*8 +: 8] = m[7:0];
          end
        end
        queue_frame();
      end
      PAT_WIPE: begin
        m_frame[m_wipe_head] = wipe_rgb(m_wipe_sel);
        queue_frame();
        m_wipe_head++;
        if (m_wipe_head >= PixCount) begin
          m_wipe_head = 0;
          m_wipe_sel = (m_wipe_sel + 1) % 6;
          fill_model(24'h0);
        end
      end
      default: ;
    endcase
  endfunction

  // Frame contents of a pattern start.
  function automatic void start_pattern();
    int unsigned m;
    int unsigned r;
    int unsigned g;
    int unsigned b;
    case (m_pattern)
      PAT_RED:  fill_model(24'hFF0000);
      PAT_FIRE: fill_model(24'h0A0000);
      PAT_RAINBOW: begin
        for (int i = 0; i < PixCount; i++) begin
          m = i * 40;
          r = m % 255;
          if (m <= 255) g = (255 - m) % 255;
          else g = (256 - ((m - 255) % 255)) & 8'hFF;
          b = (i * 80) % 255;
          m_frame[i] = {r[7:0], g[7:0], b[7:0]};
        end
      end
      PAT_OFF, PAT_CHASE, PAT_FADE, PAT_TWINKLE, PAT_RAIN, PAT_WIPE: fill_model(24'h0);
      default: ;
    endcase
    queue_frame();
  endfunction

  // Updates the model for one accepted item and queues its pixels.
  function automatic void predict_pixels(input logic [2:0] mode, input logic [31:0] now,
                                         input logic [7:0] idx, input logic [23:0] rgb);
    pixel_res_t p;
    case (mode)
      MODE_TICK: begin
        if (m_pattern >= PAT_CHASE && (now - m_last_step) >= {16'h0, m_interval}) begin
          m_last_step = now;
          step_animation();
        end
      end
      MODE_WRITE: begin
        if (idx >= PixCount) begin
          p = '{idx: 6'd0, red: 8'd0, green: 8'd0, blue: 8'd0, bright: m_bright,
                bad: 1'b1, last: 1'b1};
          pending_pixels.push_back(p);
        end else begin
          m_frame[idx] = rgb;
          queue_frame();
        end
      end
      MODE_FILL: begin
        fill_model(rgb);
        queue_frame();
      end
      MODE_START:   start_pattern();
      MODE_REFRESH: queue_frame();
      default: ;
    endcase
  endfunction

  // Offers one item until it is taken, then idles a random gap.
  task automatic send_item(input logic [2:0] mode, input logic [31:0] now,
                           input logic [7:0] idx, input logic [23:0] rgb);
    int gap;
    push          <= 1'b1;
    mode_i        <= mode;
    now_ms_i      <= now;
    pixel_index_i <= idx;
    red_in_i      <= rgb[23:16];
    green_in_i    <= rgb[15:8];
    blue_in_i     <= rgb[7:0];
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PATTERN:  m_pattern  = data[3:0];
      CFG_BRIGHT:   m_bright   = data[7:0];
      CFG_INTERVAL: m_interval = data;
      default: ;
    endcase
  endtask

  // Lets the engine settle so the registers may be written.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // Result side: checks each taken item and stalls at random.
  initial begin
    int stall_left;
    int hold_left;
    pixel_res_t want;
    stall_left = 0;
    hold_left  = 0;
    pop        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          report("unexpected item", out_index_o, 0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_index_o != want.idx) report("index", out_index_o, want.idx);
          if (out_red_o != want.red) report("red", out_red_o, want.red);
          if (out_green_o != want.green) report("green", out_green_o, want.green);
          if (out_blue_o != want.blue) report("blue", out_blue_o, want.blue);
          if (out_brightness_o != want.bright) report("brightness", out_brightness_o, want.bright);
          if (bad_index_o != want.bad) report("bad_index", bad_index_o, want.bad);
          if (last_o != want.last) report("last", last_o, want.last);
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t  rows [$];
    stim_row_t  row;
    phase_t     phases [$];
    pixel_res_t p;
    logic [31:0] now;
    logic [2:0]  mode;
    logic [7:0]  idx;
    int          r;
    int          span;

    cycles = 0;
    mismatches = 0;
    idle_free = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    mode_i = MODE_TICK;
    now_ms_i = '0;
    pixel_index_i = '0;
    red_in_i = '0;
    green_in_i = '0;
    blue_in_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PATTERN;
    cfg_data_i = '0;

    m_pattern = PAT_OFF;
    m_bright = 8'd50;
    m_interval = 16'd50;
    fill_model(24'h0);
    m_last_step = '0;
    m_chase_head = 0;
    m_fade_level = 0;
    m_fade_falling = 1'b0;
    m_wipe_head = 0;
    m_wipe_sel = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset settings.
    rows = '{
      '{MODE_REFRESH, 32'h0,        8'd0,   24'h000000, ROW_SOLID},
      '{MODE_WRITE,   32'h0,        8'd0,   24'hFFFFFF, ROW_MODEL},
      '{MODE_WRITE,   32'h0,        8'd59,  24'h0180FE, ROW_MODEL},
      '{MODE_WRITE,   32'h0,        8'd60,  24'h123456, ROW_BAD},
      '{MODE_WRITE,   32'h0,        8'd255, 24'hFFFFFF, ROW_BAD},
      '{MODE_FILL,    32'h0,        8'd0,   24'hAA5500, ROW_SOLID},
      '{MODE_FILL,    32'h0,        8'd0,   24'hFFFFFF, ROW_SOLID},
      '{MODE_START,   32'h0,        8'd0,   24'h000000, ROW_SOLID},
      '{MODE_TICK,    32'hFFFFFFFF, 8'd0,   24'h000000, ROW_MODEL},
      '{3'd5,         32'h0,        8'd3,   24'h010203, ROW_MODEL},
      '{3'd6,         32'h0,        8'd3,   24'h010203, ROW_MODEL},
      '{3'd7,         32'hFFFFFFFF, 8'd255, 24'hFFFFFF, ROW_MODEL},
      '{MODE_FILL,    32'h0,        8'd0,   24'h000000, ROW_SOLID},
      '{MODE_WRITE,   32'h0,        8'd30,  24'h800001, ROW_MODEL},
      '{MODE_WRITE,   32'h0,        8'd170, 24'h7F7F7F, ROW_BAD},
      '{MODE_REFRESH, 32'h0,        8'd0,   24'h000000, ROW_MODEL}
    };
    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == ROW_MODEL) begin
        predict_pixels(row.mode, row.now, row.idx, row.rgb);
      end else begin
        // Keep the model in step, then replace its pixels with typed ones.
        r = pending_pixels.size();
        predict_pixels(row.mode, row.now, row.idx, row.rgb);
        while (pending_pixels.size() > r) void'(pending_pixels.pop_back());
        if (row.kind == ROW_BAD) begin
          p = '{idx: 6'd0, red: 8'd0, green: 8'd0, blue: 8'd0, bright: 8'd50,
                bad: 1'b1, last: 1'b1};
          pending_pixels.push_back(p);
        end else begin
          for (int k = 0; k < PixCount; k++) begin
            p = '{idx: k[5:0], red: row.rgb[23:16], green: row.rgb[15:8],
                  blue: row.rgb[7:0], bright: 8'd50, bad: 1'b0, last: k == PixCount - 1};
            pending_pixels.push_back(p);
          end
        end
      end
      send_item(row.mode, row.now, row.idx, row.rgb);
    end

    // Register settings of the random phases, extremes among them.
    phases = '{
      '{16'(PAT_OFF),     16'd50,  16'd50,    20,  30, 1'b0},
      '{16'(PAT_RED),     16'd255, 16'd1,     25,  30, 1'b1},
      '{16'(PAT_RAINBOW), 16'd0,   16'd65535, 25,  30, 1'b0},
      '{16'(PAT_CHASE),   16'd50,  16'd1,     70,  70, 1'b0},
      '{16'(PAT_FADE),    16'd128, 16'd0,     70,  80, 1'b0},
      '{16'(PAT_TWINKLE), 16'd200, 16'd10,    40,  60, 1'b0},
      '{16'(PAT_FIRE),    16'd1,   16'd50,    20,  50, 1'b0},
      '{16'(PAT_RAIN),    16'd77,  16'd3,     20,  50, 1'b1},
      '{16'(PAT_WIPE),    16'd254, 16'd1,     130, 80, 1'b0},
      '{16'hFFFF,         16'hFFFF, 16'd65535, 25, 50, 1'b0},
      '{16'd9,            16'd33,  16'd2,     15,  50, 1'b0},
      '{16'(PAT_CHASE),   16'd170, 16'd65534, 25,  60, 1'b0}
    };
    now = $urandom;
    foreach (phases[ph]) begin
      drain();
      if (ph == phases.size() - 1) write_reg(CFG_SPARE, 16'hFFFF);
      write_reg(CFG_PATTERN, phases[ph].pat);
      write_reg(CFG_BRIGHT, phases[ph].bright);
      write_reg(CFG_INTERVAL, phases[ph].interval);
      idle_free = phases[ph].idle_free;
      // Long receiver hold while items keep coming, so the input stalls.
      if (m_pattern == PAT_CHASE && ph == 3) hold_req = 1'b1;
      for (int n = 0; n < phases[ph].items; n++) begin
        r = $urandom_range(0, 99);
        idx = 8'($urandom_range(0, 59));
        span = 2 * int'(m_interval) + 2;
        if (r < phases[ph].tick_pct) begin
          mode = MODE_TICK;
          if ($urandom_range(0, 19) == 0) now = $urandom;
          else now = now + $urandom_range(0, span);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 35) mode = MODE_WRITE;
          else if (r < 50) mode = MODE_FILL;
          else if (r < 70) mode = MODE_START;
          else if (r < 88) mode = MODE_REFRESH;
          else mode = 3'($urandom_range(5, 7));
          if ($urandom_range(0, 4) == 0) idx = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 9) == 0) now = $urandom;
        end
        row.rgb = 24'($urandom);
        predict_pixels(mode, now, idx, row.rgb);
        send_item(mode, now, idx, row.rgb);
      end
    end
    drain();

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lspe_pkg.sv
hw/rtl/lspe_cmd_fifo.sv
hw/rtl/lspe_front.sv
hw/rtl/lspe_back.sv
hw/rtl/led_strip_pattern_engine_core.sv
hw/rtl/lspe_checker.sv
tb/sv/tb_top.sv
